/* rtl/core/lcw_pkg.sv */
// Shared types, constants and character tables for the Cyrillic glyph writer.
// Used by lcw_front, lcw_queue, lcw_back and lcd_cyrillic_glyph_writer.
`timescale 1ns / 1ps

package lcw_pkg;

  localparam int GLYPH_SLOTS_DEF = 8;
  localparam int SLOT_BITS       = 3;
  localparam int GLYPH_BITS      = 6;
  localparam int ADDR_BITS       = 7;
  localparam int ROW_BITS        = 5;
  localparam int PATTERN_ROWS    = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CMD_CGRAM = 8'h40;
  localparam logic [7:0] CMD_DDRAM = 8'h80;

  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  // byte positions of a glyph upload sequence
  localparam logic [3:0] BYTE_CGRAM = 4'd0;
  localparam logic [3:0] BYTE_ROW0  = 4'd1;
  localparam logic [3:0] BYTE_DDRAM = 4'd9;
  localparam logic [3:0] BYTE_SLOT  = 4'd10;

  typedef struct packed {
    logic                  miss;
    logic                  rs;
    logic [7:0]            value;
    logic [GLYPH_BITS-1:0] glyph;
    logic [SLOT_BITS-1:0]  slot;
    logic [ADDR_BITS-1:0]  addr;
  } job_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } latin_t;

  typedef struct packed {
    logic                  hit;
    logic [GLYPH_BITS-1:0] idx;
  } glyph_t;

  function automatic latin_t latin_lookup(input logic [7:0] code);
    latin_t r;
    r.hit = 1'b1;
    case (code)
      8'd192:  r.value = 8'h41;
      8'd194:  r.value = 8'h42;
      8'd197:  r.value = 8'h45;
      8'd202:  r.value = 8'h4B;
      8'd204:  r.value = 8'h4D;
      8'd205:  r.value = 8'h48;
      8'd206:  r.value = 8'h4F;
      8'd208:  r.value = 8'h50;
      8'd209:  r.value = 8'h43;
      8'd210:  r.value = 8'h54;
      8'd211:  r.value = 8'h59;
      8'd213:  r.value = 8'h58;
      8'd224:  r.value = 8'h61;
      8'd229:  r.value = 8'h65;
      8'd232:  r.value = 8'h75;
      8'd238:  r.value = 8'h6F;
      8'd240:  r.value = 8'h70;
      8'd241:  r.value = 8'h63;
      8'd242:  r.value = 8'h6D;
      8'd243:  r.value = 8'h79;
      8'd245:  r.value = 8'h78;
      default: begin
        r.hit   = 1'b0;
        r.value = code;
      end
    endcase
    return r;
  endfunction

  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t r;
    r.hit = 1'b1;
    case (code)
      8'd193:  r.idx = 6'd0;
      8'd195:  r.idx = 6'd1;
      8'd196:  r.idx = 6'd2;
      8'd168:  r.idx = 6'd3;
      8'd198:  r.idx = 6'd4;
      8'd199:  r.idx = 6'd5;
      8'd200:  r.idx = 6'd6;
      8'd201:  r.idx = 6'd7;
      8'd203:  r.idx = 6'd8;
      8'd207:  r.idx = 6'd9;
      8'd212:  r.idx = 6'd10;
      8'd214:  r.idx = 6'd11;
      8'd215:  r.idx = 6'd12;
      8'd216:  r.idx = 6'd13;
      8'd217:  r.idx = 6'd14;
      8'd218:  r.idx = 6'd15;
      8'd219:  r.idx = 6'd16;
      8'd220:  r.idx = 6'd17;
      8'd221:  r.idx = 6'd18;
      8'd222:  r.idx = 6'd19;
      8'd223:  r.idx = 6'd20;
      8'd225:  r.idx = 6'd21;
      8'd226:  r.idx = 6'd22;
      8'd227:  r.idx = 6'd23;
      8'd228:  r.idx = 6'd24;
      8'd184:  r.idx = 6'd25;
      8'd230:  r.idx = 6'd26;
      8'd231:  r.idx = 6'd27;
      8'd233:  r.idx = 6'd28;
      8'd234:  r.idx = 6'd29;
      8'd235:  r.idx = 6'd30;
      8'd236:  r.idx = 6'd31;
      8'd237:  r.idx = 6'd32;
      8'd239:  r.idx = 6'd33;
      8'd244:  r.idx = 6'd34;
      8'd246:  r.idx = 6'd35;
      8'd247:  r.idx = 6'd36;
      8'd248:  r.idx = 6'd37;
      8'd249:  r.idx = 6'd38;
      8'd250:  r.idx = 6'd39;
      8'd251:  r.idx = 6'd40;
      8'd252:  r.idx = 6'd41;
      8'd253:  r.idx = 6'd42;
      8'd254:  r.idx = 6'd43;
      8'd255:  r.idx = 6'd44;
      default: begin
        r.hit = 1'b0;
        r.idx = '0;
      end
    endcase
    return r;
  endfunction

  // pattern row 0 sits in the top five bits
  function automatic logic [PATTERN_ROWS*ROW_BITS-1:0] glyph_pattern(
      input logic [GLYPH_BITS-1:0] idx);
    logic [PATTERN_ROWS*ROW_BITS-1:0] p;
    case (idx)
      6'd0:  p = {5'h1F, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h00};
      6'd1:  p = {5'h1F, 5'h11, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h00};
      6'd2:  p = {5'h0F, 5'h05, 5'h05, 5'h09, 5'h11, 5'h1F, 5'h11, 5'h00};
      6'd3:  p = {5'h0A, 5'h00, 5'h1F, 5'h10, 5'h1E, 5'h10, 5'h1F, 5'h00};
      6'd4:  p = {5'h15, 5'h15, 5'h15, 5'h0E, 5'h15, 5'h15, 5'h15, 5'h00};
      6'd5:  p = {5'h1E, 5'h01, 5'h01, 5'h06, 5'h01, 5'h01, 5'h1E, 5'h00};
      6'd6:  p = {5'h11, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h11, 5'h00};
      6'd7:  p = {5'h15, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h11, 5'h00};
      6'd8:  p = {5'h0F, 5'h05, 5'h05, 5'h05, 5'h05, 5'h15, 5'h09, 5'h00};
      6'd9:  p = {5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h00};
      6'd10: p = {5'h0E, 5'h04, 5'h0E, 5'h15, 5'h0E, 5'h04, 5'h0E, 5'h00};
      6'd11: p = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F, 5'h01};
      6'd12: p = {5'h11, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h01, 5'h00};
      6'd13: p = {5'h15, 5'h15, 5'h15, 5'h15, 5'h15, 5'h15, 5'h1F, 5'h00};
      6'd14: p = {5'h15, 5'h15, 5'h15, 5'h15, 5'h15, 5'h15, 5'h1F, 5'h01};
      6'd15: p = {5'h18, 5'h08, 5'h08, 5'h0E, 5'h09, 5'h09, 5'h0E, 5'h00};
      6'd16: p = {5'h11, 5'h11, 5'h11, 5'h19, 5'h15, 5'h15, 5'h19, 5'h00};
      6'd17: p = {5'h08, 5'h08, 5'h08, 5'h0E, 5'h09, 5'h09, 5'h0E, 5'h00};
      6'd18: p = {5'h0E, 5'h11, 5'h05, 5'h0B, 5'h01, 5'h11, 5'h0E, 5'h00};
      6'd19: p = {5'h12, 5'h15, 5'h15, 5'h1D, 5'h15, 5'h15, 5'h12, 5'h00};
      6'd20: p = {5'h0F, 5'h11, 5'h11, 5'h0F, 5'h05, 5'h09, 5'h11, 5'h00};
      6'd21: p = {5'h03, 5'h0C, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E, 5'h00};
      6'd22: p = {5'h00, 5'h00, 5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E, 5'h00};
      6'd23: p = {5'h00, 5'h00, 5'h1F, 5'h11, 5'h10, 5'h10, 5'h10, 5'h00};
      6'd24: p = {5'h00, 5'h06, 5'h0A, 5'h0A, 5'h0A, 5'h1F, 5'h11, 5'h00};
      6'd25: p = {5'h0A, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E, 5'h00};
      6'd26: p = {5'h00, 5'h00, 5'h15, 5'h15, 5'h0E, 5'h15, 5'h15, 5'h00};
      6'd27: p = {5'h00, 5'h00, 5'h1E, 5'h01, 5'h0E, 5'h01, 5'h1E, 5'h00};
      6'd28: p = {5'h04, 5'h00, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0D, 5'h00};
      6'd29: p = {5'h00, 5'h00, 5'h11, 5'h12, 5'h1C, 5'h12, 5'h11, 5'h00};
      6'd30: p = {5'h00, 5'h00, 5'h07, 5'h09, 5'h09, 5'h09, 5'h11, 5'h00};
      6'd31: p = {5'h00, 5'h00, 5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h00};
      6'd32: p = {5'h00, 5'h00, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h00};
      6'd33: p = {5'h00, 5'h00, 5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h00};
      6'd34: p = {5'h02, 5'h04, 5'h0E, 5'h15, 5'h0E, 5'h04, 5'h08, 5'h00};
      6'd35: p = {5'h00, 5'h00, 5'h12, 5'h12, 5'h12, 5'h12, 5'h1F, 5'h01};
      6'd36: p = {5'h00, 5'h00, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h00};
      6'd37: p = {5'h00, 5'h00, 5'h15, 5'h15, 5'h15, 5'h15, 5'h1F, 5'h00};
      6'd38: p = {5'h00, 5'h00, 5'h15, 5'h15, 5'h15, 5'h15, 5'h1F, 5'h01};
      6'd39: p = {5'h00, 5'h00, 5'h18, 5'h08, 5'h0E, 5'h09, 5'h0E, 5'h00};
      6'd40: p = {5'h00, 5'h00, 5'h11, 5'h11, 5'h19, 5'h15, 5'h19, 5'h00};
      6'd41: p = {5'h00, 5'h00, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h1E, 5'h00};
      6'd42: p = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h07, 5'h11, 5'h0E, 5'h00};
      6'd43: p = {5'h00, 5'h00, 5'h12, 5'h15, 5'h1D, 5'h15, 5'h12, 5'h00};
      6'd44: p = {5'h00, 5'h00, 5'h0F, 5'h11, 5'h0F, 5'h09, 5'h11, 5'h00};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

/* rtl/core/lcw_front.sv */
// Front end: accepts input words, classifies the character code, keeps the
// glyph slot table and address counter, and writes one job into the queue.
// Depends on lcw_pkg.
`timescale 1ns / 1ps

module lcw_front #(
  parameter int GLYPH_SLOTS = lcw_pkg::GLYPH_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic          queue_full,
  input  logic          func,
  input  logic [7:0]    char_code,
  input  logic          row,
  input  logic [5:0]    column,
  output logic          job_write,
  output lcw_pkg::job_t job
);

  localparam int IDX_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;

  logic [lcw_pkg::GLYPH_BITS-1:0] slot_glyph [GLYPH_SLOTS];
  logic [GLYPH_SLOTS-1:0]         slot_valid;
  logic [IDX_W-1:0]               next_slot;
  logic [IDX_W-1:0]               next_slot_next;
  logic [lcw_pkg::ADDR_BITS-1:0]  address_counter;
  logic [lcw_pkg::ADDR_BITS-1:0]  address_counter_next;

  lcw_pkg::latin_t lat;
  lcw_pkg::glyph_t gly;
  logic             slot_hit;
  logic [IDX_W-1:0] hit_idx;
  logic             upload;

  assign job_write = push && !queue_full;
  assign lat = lcw_pkg::latin_lookup(char_code);
  assign gly = lcw_pkg::glyph_lookup(char_code);
  assign next_slot_next = (next_slot == IDX_W'(GLYPH_SLOTS - 1)) ? '0 : next_slot + 1'b1;

  // lowest matching slot wins
  always_comb begin
    slot_hit = 1'b0;
    hit_idx  = '0;
    for (int i = GLYPH_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_glyph[i] == gly.idx) begin
        slot_hit = 1'b1;
        hit_idx  = IDX_W'(i);
      end
    end
  end

  always_comb begin
    job.miss  = 1'b0;
    job.rs    = lcw_pkg::RS_DATA;
    job.value = char_code;
    job.glyph = gly.idx;
    job.slot  = lcw_pkg::SLOT_BITS'(next_slot);
    job.addr  = address_counter;
    upload    = 1'b0;
    if (func) begin
      address_counter_next = {row, column};
      job.rs    = lcw_pkg::RS_COMMAND;
      job.value = lcw_pkg::CMD_DDRAM | {1'b0, row, column};
    end else begin
      address_counter_next = address_counter + 1'b1;
      if (lat.hit) begin
        job.value = lat.value;
      end else if (gly.hit) begin
        if (slot_hit) begin
          job.value = 8'(hit_idx);
        end else begin
          job.miss = 1'b1;
          upload   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid      <= '0;
      next_slot       <= '0;
      address_counter <= '0;
    end else if (job_write) begin
      address_counter <= address_counter_next;
      if (upload) begin
        slot_valid[next_slot] <= 1'b1;
        next_slot             <= next_slot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_write && upload) begin
      slot_glyph[next_slot] <= gly.idx;
    end
  end

endmodule

/* rtl/core/lcw_queue.sv */
// Short job queue between the front end and the write sequencer.
// Depends on lcw_pkg.
`timescale 1ns / 1ps

module lcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  lcw_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output lcw_pkg::job_t rd_job
);

  lcw_pkg::job_t                 entries [lcw_pkg::QUEUE_DEPTH];
  logic [lcw_pkg::QPTR_W-1:0]    wr_ptr;
  logic [lcw_pkg::QPTR_W-1:0]    rd_ptr;
  logic [lcw_pkg::QCNT_W-1:0]    count;
  logic                          do_wr;
  logic                          do_rd;

  assign full     = (count == lcw_pkg::QCNT_W'(lcw_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

/* rtl/core/lcw_back.sv */
// Back end: expands each job into bus writes, splits bytes into nibbles in
// four-bit mode, and holds the oldest write in the output register.
// Depends on lcw_pkg.
`timescale 1ns / 1ps

module lcw_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          four_bit_mode,
  input  logic          job_valid,
  input  lcw_pkg::job_t job_in,
  output logic          job_take,
  input  logic          pop,
  output logic          empty,
  output logic          reg_select,
  output logic [7:0]    bus_value,
  output logic          last
);

  lcw_pkg::job_t job;
  logic          busy;
  logic [3:0]    bidx;
  logic          half;
  logic          out_valid;

  logic          cur_rs;
  logic [7:0]    cur_byte;
  logic [7:0]    cur_write;
  logic          last_byte;
  logic          last_write;
  logic          advance;
  logic [3:0]    row_pos;
  logic [lcw_pkg::PATTERN_ROWS*lcw_pkg::ROW_BITS-1:0] pattern;

  assign empty   = !out_valid;
  assign advance = busy && (!out_valid || pop);
  assign pattern = lcw_pkg::glyph_pattern(job.glyph);
  assign row_pos = bidx - lcw_pkg::BYTE_ROW0;

  always_comb begin
    if (!job.miss) begin
      cur_rs    = job.rs;
      cur_byte  = job.value;
      last_byte = 1'b1;
    end else begin
      last_byte = (bidx == lcw_pkg::BYTE_SLOT);
      case (bidx)
        lcw_pkg::BYTE_CGRAM: begin
          cur_rs   = lcw_pkg::RS_COMMAND;
          cur_byte = lcw_pkg::CMD_CGRAM | {2'b00, job.slot, 3'b000};
        end
        lcw_pkg::BYTE_DDRAM: begin
          cur_rs   = lcw_pkg::RS_COMMAND;
          cur_byte = lcw_pkg::CMD_DDRAM | {1'b0, job.addr};
        end
        lcw_pkg::BYTE_SLOT: begin
          cur_rs   = lcw_pkg::RS_DATA;
          cur_byte = 8'(job.slot);
        end
        default: begin
          cur_rs   = lcw_pkg::RS_DATA;
          cur_byte = 8'(pattern[(lcw_pkg::PATTERN_ROWS - 1 - row_pos[2:0]) *
                                lcw_pkg::ROW_BITS +: lcw_pkg::ROW_BITS]);
        end
      endcase
    end
  end

  always_comb begin
    if (!four_bit_mode) begin
      cur_write  = cur_byte;
      last_write = last_byte;
    end else if (!half) begin
      cur_write  = {cur_byte[7:4], 4'h0};
      last_write = 1'b0;
    end else begin
      cur_write  = {cur_byte[3:0], 4'h0};
      last_write = last_byte;
    end
  end

  // load the next job when idle or on the final write of the current one
  assign job_take = job_valid && (!busy || (advance && last_write));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      bidx      <= lcw_pkg::BYTE_CGRAM;
      half      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (job_take) begin
        busy <= 1'b1;
        bidx <= lcw_pkg::BYTE_CGRAM;
        half <= 1'b0;
      end else if (advance) begin
        if (last_write) begin
          busy <= 1'b0;
          half <= 1'b0;
        end else if (four_bit_mode && !half) begin
          half <= 1'b1;
        end else begin
          half <= 1'b0;
          bidx <= bidx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      job <= job_in;
    end
    if (advance) begin
      reg_select <= cur_rs;
      bus_value  <= cur_write;
      last       <= last_write;
    end
  end

  a_bidx_range: assert property (@(posedge clk) disable iff (rst)
    bidx <= lcw_pkg::BYTE_SLOT)
    else $error("byte index past end of upload sequence");

  a_single_byte: assert property (@(posedge clk) disable iff (rst)
    busy && !job.miss |-> bidx == lcw_pkg::BYTE_CGRAM)
    else $error("single-byte job stepped its byte index");

  a_half_mode: assert property (@(posedge clk) disable iff (rst)
    half |-> four_bit_mode)
    else $error("low nibble pending in eight-bit mode");

  a_keep_busy: assert property (@(posedge clk) disable iff (rst)
    advance && !last_write |=> busy)
    else $error("job dropped before its final write");

endmodule

/* rtl/core/lcd_cyrillic_glyph_writer.sv */
// Top level of the Cyrillic glyph writer: configuration register, front end,
// job queue and write sequencer. Depends on lcw_pkg, lcw_front, lcw_queue, lcw_back.
`timescale 1ns / 1ps

// Each input word (print a character or set the cursor) is classified in the
// cycle it is pushed and placed in a four-entry job queue, so input words are
// taken one per cycle while the queue has room. The write sequencer then sends
// one bus write per cycle while results are popped: a plain character, a Latin
// lookalike, a glyph already held in a custom slot, or a set-position command
// gives one write (two in four-bit mode); a glyph that misses the slots gives
// eleven writes (twenty-two in four-bit mode), slot command, eight pattern rows,
// address restore and slot number. The sequencer and the pop rate set the sustained
// rate. Write four_bit_mode via cfg_write/cfg_data only while idle; not enforced.
module lcd_cyrillic_glyph_writer #(
  parameter int GLYPH_SLOTS = lcw_pkg::GLYPH_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       push,
  output logic       full,
  input  logic       func,
  input  logic [7:0] char_code,
  input  logic       row,
  input  logic [5:0] column,
  output logic       empty,
  input  logic       pop,
  output logic       reg_select,
  output logic [7:0] bus_value,
  output logic       last
);

  logic          four_bit_mode;
  logic          job_write;
  lcw_pkg::job_t front_job;
  logic          job_valid;
  logic          job_take;
  lcw_pkg::job_t back_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode <= 1'b0;
    end else if (cfg_write) begin
      four_bit_mode <= cfg_data;
    end
  end

  lcw_front #(
    .GLYPH_SLOTS(GLYPH_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .queue_full (full),
    .func       (func),
    .char_code  (char_code),
    .row        (row),
    .column     (column),
    .job_write  (job_write),
    .job        (front_job)
  );

  lcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_write),
    .wr_job   (front_job),
    .full     (full),
    .rd_en    (job_take),
    .rd_valid (job_valid),
    .rd_job   (back_job)
  );

  lcw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .four_bit_mode (four_bit_mode),
    .job_valid     (job_valid),
    .job_in        (back_job),
    .job_take      (job_take),
    .pop           (pop),
    .empty         (empty),
    .reg_select    (reg_select),
    .bus_value     (bus_value),
    .last          (last)
  );

endmodule

/* bench/lcd_cyrillic_glyph_writer_test.sv */
// Self-checking bench for lcd_cyrillic_glyph_writer: directed words, then random phases in
// both bus widths, every bus write compared against an in-bench glyph slot model.
// Depends on lcw_pkg and the lcd_cyrillic_glyph_writer RTL.
`timescale 1ns / 1ps

module lcd_cyrillic_glyph_writer_test;

  localparam int SLOTS       = lcw_pkg::GLYPH_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_WORDS = 100;

  typedef struct packed {
    logic       rs;
    logic [7:0] value;
    logic       last;
  } bus_write_t;

  typedef struct packed {
    logic       mode;
    logic       f;
    logic [7:0] c;
    logic       r;
    logic [5:0] col;
    logic       typed;
    logic       rs;
    logic [7:0] b;
  } plan_row_t;

  localparam logic [7:0] LOOK_CODE [21] = '{
    8'd192, 8'd194, 8'd197, 8'd202, 8'd204, 8'd205, 8'd206, 8'd208, 8'd209, 8'd210, 8'd211,
    8'd213, 8'd224, 8'd229, 8'd232, 8'd238, 8'd240, 8'd241, 8'd242, 8'd243, 8'd245};
  localparam logic [7:0] LOOK_LATIN [21] = '{
    8'h41, 8'h42, 8'h45, 8'h4B, 8'h4D, 8'h48, 8'h4F, 8'h50, 8'h43, 8'h54, 8'h59,
    8'h58, 8'h61, 8'h65, 8'h75, 8'h6F, 8'h70, 8'h63, 8'h6D, 8'h79, 8'h78};
  localparam logic [7:0] GLYPH_CODE [45] = '{
    8'd193, 8'd195, 8'd196, 8'd168, 8'd198, 8'd199, 8'd200, 8'd201, 8'd203, 8'd207,
    8'd212, 8'd214, 8'd215, 8'd216, 8'd217, 8'd218, 8'd219, 8'd220, 8'd221, 8'd222,
    8'd223, 8'd225, 8'd226, 8'd227, 8'd228, 8'd184, 8'd230, 8'd231, 8'd233, 8'd234,
    8'd235, 8'd236, 8'd237, 8'd239, 8'd244, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250,
    8'd251, 8'd252, 8'd253, 8'd254, 8'd255};
  // pattern row 0 in the top byte
  localparam logic [63:0] GLYPH_ROWS [45] = '{
    64'h1F11101E11111E00, 64'h1F11101010101000, 64'h0F050509111F1100, 64'h0A001F101E101F00,
    64'h1515150E15151500, 64'h1E01010601011E00, 64'h1111131519111100, 64'h1511131519111100,
    64'h0F05050505150900, 64'h1F11111111111100, 64'h0E040E150E040E00, 64'h1111111111111F01,
    64'h1111110F01010100, 64'h1515151515151F00, 64'h1515151515151F01, 64'h1808080E09090E00,
    64'h1111111915151900, 64'h0808080E09090E00, 64'h0E11050B01110E00, 64'h1215151D15151200,
    64'h0F11110F05091100, 64'h030C101E11110E00, 64'h00001E111E111E00, 64'h00001F1110101000,
    64'h00060A0A0A1F1100, 64'h0A000E111F100E00, 64'h000015150E151500, 64'h00001E010E011E00,
    64'h0400111111130D00, 64'h000011121C121100, 64'h0000070909091100, 64'h0000111B15111100,
    64'h000011111F111100, 64'h00001F1111111100, 64'h02040E150E040800, 64'h0000121212121F01,
    64'h000011110F010100, 64'h0000151515151F00, 64'h0000151515151F01, 64'h000018080E090E00,
    64'h0000111119151900, 64'h000010101E111E00, 64'h00000E1107110E00, 64'h000012151D151200,
    64'h00000F110F091100};

  // mode, func, code, row, column, typed, rs, byte
  localparam plan_row_t PLAN [25] = '{
    '{1'b0, 1'b1, 8'd0,   1'b0, 6'd0,  1'b1, lcw_pkg::RS_COMMAND, 8'h80},
    '{1'b0, 1'b1, 8'd0,   1'b1, 6'd39, 1'b1, lcw_pkg::RS_COMMAND, 8'hE7},
    '{1'b0, 1'b1, 8'd0,   1'b0, 6'd63, 1'b1, lcw_pkg::RS_COMMAND, 8'hBF},
    '{1'b0, 1'b1, 8'd0,   1'b1, 6'd63, 1'b1, lcw_pkg::RS_COMMAND, 8'hFF},
    '{1'b0, 1'b0, 8'd0,   1'b0, 6'd0,  1'b1, lcw_pkg::RS_DATA,    8'h00},
    '{1'b0, 1'b0, 8'd255, 1'b0, 6'd0,  1'b0, lcw_pkg::RS_DATA,    8'h00},
    '{1'b0, 1'b0, 8'd255, 1'b0, 6'd0,  1'b1, lcw_pkg::RS_DATA,    8'h00},
    '{1'b0, 1'b0, 8'd192, 1'b0, 6'd0,  1'b1, lcw_pkg::RS_DATA,    8'h41},
    '{1'b0, 1'b0, 8'd245, 1'b0, 6'd0,  1'b1, lcw_pkg::RS_DATA,    8'h78},
    '{1'b0, 1'b0, 8'd127, 1'b0, 6'd0,  1'b1, lcw_pkg::RS_DATA,    8'h7F},
    '{1'b0, 1'b0, 8'd191, 1'b0, 6'd0,  1'b1, lcw_pkg::RS_DATA,    8'hBF},
    '{1'b0, 1'b0, 8'd168, 1'b0, 6'd0,  1'b0, lcw_pkg::RS_DATA,    8'h00},
    '{1'b0, 1'b0, 8'd184, 1'b0, 6'd0,  1'b0, lcw_pkg::RS_DATA,    8'h00},
    '{1'b0, 1'b0, 8'd193, 1'b0, 6'd0,  1'b0, lcw_pkg::RS_DATA,    8'h00},
    '{1'b0, 1'b0, 8'd195, 1'b0, 6'd0,  1'b0, lcw_pkg::RS_DATA,    8'h00},
    '{1'b0, 1'b0, 8'd196, 1'b0, 6'd0,  1'b0, lcw_pkg::RS_DATA,    8'h00},
    '{1'b0, 1'b0, 8'd198, 1'b0, 6'd0,  1'b0, lcw_pkg::RS_DATA,    8'h00},
    '{1'b0, 1'b0, 8'd199, 1'b0, 6'd0,  1'b0, lcw_pkg::RS_DATA,    8'h00},
    '{1'b0, 1'b0, 8'd200, 1'b0, 6'd0,  1'b0, lcw_pkg::RS_DATA,    8'h00},
    '{1'b0, 1'b0, 8'd255, 1'b0, 6'd0,  1'b0, lcw_pkg::RS_DATA,    8'h00},
    '{1'b1, 1'b1, 8'd0,   1'b1, 6'd2,  1'b1, lcw_pkg::RS_COMMAND, 8'hC2},
    '{1'b1, 1'b0, 8'd65,  1'b0, 6'd0,  1'b1, lcw_pkg::RS_DATA,    8'h41},
    '{1'b1, 1'b0, 8'd201, 1'b0, 6'd0,  1'b0, lcw_pkg::RS_DATA,    8'h00},
    '{1'b1, 1'b0, 8'd224, 1'b0, 6'd0,  1'b1, lcw_pkg::RS_DATA,    8'h61},
    '{1'b1, 1'b0, 8'd201, 1'b0, 6'd0,  1'b1, lcw_pkg::RS_DATA,    8'h02}};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;
  logic       push = 1'b0;
  logic       func = 1'b0;
  logic [7:0] char_code = 8'd0;
  logic       row = 1'b0;
  logic [5:0] column = 6'd0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic       reg_select;
  logic [7:0] bus_value;
  logic       last;

  logic       want_on = 1'b0;
  logic       want_rs = 1'b0;
  logic [7:0] want_byte = 8'd0;
  logic       calm = 1'b0;
  logic       mode_now = 1'b0;

  // model state
  logic                           four_bit = 1'b0;
  logic [lcw_pkg::GLYPH_BITS-1:0] slot_glyph [SLOTS];
  logic                           slot_used [SLOTS];
  logic [lcw_pkg::SLOT_BITS-1:0]  upload_slot = '0;
  logic [lcw_pkg::ADDR_BITS-1:0]  cursor = '0;

  bus_write_t item_writes [$];
  bus_write_t expected_writes [$];

  int words_in = 0;
  int writes_checked = 0;
  int glyph_uploads = 0;
  int mismatches = 0;
  int cycle_count = 0;

  lcd_cyrillic_glyph_writer dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .func(func),
    .char_code(char_code),
    .row(row),
    .column(column),
    .empty(empty),
    .pop(pop),
    .reg_select(reg_select),
    .bus_value(bus_value),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void emit_byte(input logic rs, input logic [7:0] v);
    if (four_bit) begin
      item_writes.push_back(bus_write_t'{rs, {v[7:4], 4'h0}, 1'b0});
      item_writes.push_back(bus_write_t'{rs, {v[3:0], 4'h0}, 1'b0});
    end else begin
      item_writes.push_back(bus_write_t'{rs, v, 1'b0});
    end
  endfunction

  function automatic void predict_glyph_writes(input logic f, input logic [7:0] c,
                                               input logic r, input logic [5:0] col);
    int look;
    int g;
    int slot;
    item_writes.delete();
    if (f) begin
      cursor = {r, col};
      emit_byte(lcw_pkg::RS_COMMAND, lcw_pkg::CMD_DDRAM | {1'b0, cursor});
      return;
    end
    look = -1;
    g = -1;
    for (int i = 0; i < 21; i++) if (look < 0 && LOOK_CODE[i] == c) look = i;
    if (look < 0)
      for (int i = 0; i < 45; i++) if (g < 0 && GLYPH_CODE[i] == c) g = i;
    if (look >= 0) begin
      emit_byte(lcw_pkg::RS_DATA, LOOK_LATIN[look]);
    end else if (g >= 0) begin
      slot = -1;
      for (int i = 0; i < SLOTS; i++)
        if (slot < 0 && slot_used[i] && slot_glyph[i] == g[lcw_pkg::GLYPH_BITS-1:0])
          slot = i;
      if (slot < 0) begin
        slot = int'(upload_slot) % SLOTS;
        emit_byte(lcw_pkg::RS_COMMAND, lcw_pkg::CMD_CGRAM | {2'b00, slot[2:0], 3'b000});
        for (int k = 0; k < 8; k++)
          emit_byte(lcw_pkg::RS_DATA, GLYPH_ROWS[g][63 - 8 * k -: 8]);
        slot_glyph[slot] = g[lcw_pkg::GLYPH_BITS-1:0];
        slot_used[slot] = 1'b1;
        upload_slot = lcw_pkg::SLOT_BITS'((slot + 1) % SLOTS);
        emit_byte(lcw_pkg::RS_COMMAND, lcw_pkg::CMD_DDRAM | {1'b0, cursor});
        glyph_uploads++;
      end
      emit_byte(lcw_pkg::RS_DATA, 8'(slot));
    end else begin
      emit_byte(lcw_pkg::RS_DATA, c);
    end
    cursor = cursor + 1'b1;
  endfunction

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_glyph[i] = '0;
      slot_used[i] = 1'b0;
    end
  end

  always @(posedge clk) begin
    bus_write_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes pending", cycle_count,
               expected_writes.size());
      $display("simulation failed");
      $finish;
    end else if (!rst) begin
      if (cfg_write) four_bit = cfg_data;
      if (push && !full) begin
        predict_glyph_writes(func, char_code, row, column);
        if (want_on) begin
          item_writes.delete();
          emit_byte(want_rs, want_byte);
        end
        item_writes[item_writes.size() - 1].last = 1'b1;
        foreach (item_writes[i]) expected_writes.push_back(item_writes[i]);
        words_in++;
      end
      if (pop && !empty) begin
        writes_checked++;
        if (expected_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected write rs=%0b value=%02h last=%0b", reg_select, bus_value,
                     last);
        end else begin
          want = expected_writes.pop_front();
          if (reg_select !== want.rs || bus_value !== want.value || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"write %0d: expected rs=%0b value=%02h last=%0b, ",
                        "got rs=%0b value=%02h last=%0b"},
                       writes_checked, want.rs, want.value, want.last,
                       reg_select, bus_value, last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= calm || ($urandom_range(99) >= 9);
  end

  task automatic drain_writes();
    push <= 1'b0;
    @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain_writes();
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= m;
    mode_now = m;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_word(input logic f, input logic [7:0] c, input logic r,
                           input logic [5:0] col, input logic typed, input logic rs,
                           input logic [7:0] b);
    while (!calm && $urandom_range(99) < 9) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    func <= f;
    char_code <= c;
    row <= r;
    column <= col;
    want_on <= typed;
    want_rs <= rs;
    want_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  initial begin
    int pick;
    logic [7:0] c;
    logic [5:0] col;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_mode(1'b0);
    for (int i = 0; i < 25; i++) begin
      if (PLAN[i].mode != mode_now) set_mode(PLAN[i].mode);
      send_word(PLAN[i].f, PLAN[i].c, PLAN[i].r, PLAN[i].col, PLAN[i].typed, PLAN[i].rs,
                PLAN[i].b);
    end
    for (int ph = 0; ph < 5; ph++) begin
      calm <= (ph == 2);
      set_mode((ph == 2) ? 1'($urandom_range(1)) : 1'(ph % 3 == 0));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(49) == 0) drain_writes();
        pick = $urandom_range(99);
        // keep most glyphs in a working set a bit larger than the slot count
        if (pick < 35)
          c = ($urandom_range(3) != 0) ? GLYPH_CODE[$urandom_range(11)]
                                      : GLYPH_CODE[$urandom_range(44)];
        else if (pick < 55)
          c = LOOK_CODE[$urandom_range(20)];
        else
          c = 8'($urandom_range(255));
        col = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(39));
        send_word(1'($urandom_range(99) < 15), c, 1'($urandom_range(1)), col, 1'b0,
                  lcw_pkg::RS_DATA, 8'h00);
      end
    end
    drain_writes();
    repeat (20) @(posedge clk);
    $display("%0d words sent in both bus widths, %0d bus writes checked, %0d glyph uploads",
             words_in, writes_checked, glyph_uploads);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
